// File: design/rv64alu_pkg.sv
// shared types and encoding constants for the rv64i integer alu
package rv64alu_pkg;

  // data path width and word-form width
  localparam int XLEN   = 64;
  localparam int WORD_W = 32;

  // instruction class codes on func
  localparam logic [1:0] CLS_OP_IMM    = 2'd0;
  localparam logic [1:0] CLS_OP        = 2'd1;
  localparam logic [1:0] CLS_OP_IMM_32 = 2'd2;
  localparam logic [1:0] CLS_OP_32     = 2'd3;

  // funct3 codes
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SRL  = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // funct7 / funct6 codes
  localparam logic [6:0] F7_BASE    = 7'h00;
  localparam logic [6:0] F7_ALT     = 7'h20;
  localparam logic [5:0] F6_BASE    = 6'h00;
  localparam logic [5:0] F6_SRA     = 6'h10;
  localparam logic [5:0] F6_SLLI_UW = 6'h02;

  // internal operation selected by decode
  typedef enum logic [3:0] {
    OP_ADD,
    OP_SUB,
    OP_SLT,
    OP_SLTU,
    OP_XOR,
    OP_OR,
    OP_AND,
    OP_SLL,
    OP_SRL,
    OP_SRA
  } op_t;

  // control that travels with an item down the pipe
  typedef struct packed {
    op_t  op;
    logic word;
    logic legal;
  } ctl_t;

endpackage

// File: design/rv64alu_decode.sv
// stage 1: instruction decode, operand and shift amount selection
module rv64alu_decode #(
  parameter int XLEN = rv64alu_pkg::XLEN
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [1:0]                func,
  input  logic [31:0]               instruction,
  input  logic [4:0]                dest_index,
  input  logic [XLEN-1:0]           operand_a,
  input  logic [XLEN-1:0]           operand_b,
  input  logic                      zba_en,
  output logic                      out_valid,
  output rv64alu_pkg::ctl_t         out_ctl,
  output logic [$clog2(XLEN)-1:0]   out_shamt,
  output logic [XLEN-1:0]           out_a,
  output logic [XLEN-1:0]           out_b,
  output logic [4:0]                out_index
);

  localparam int SHW = $clog2(XLEN);
  localparam int WW  = rv64alu_pkg::WORD_W;

  logic [2:0]      f3;
  logic [6:0]      f7;
  logic [5:0]      f6;
  logic [XLEN-1:0] imm;
  logic [XLEN-1:0] lo_zext;
  logic [XLEN-1:0] lo_sext;
  logic [SHW-1:0]  sh_full;
  logic [SHW-1:0]  sh_word;

  rv64alu_pkg::ctl_t ctl_next;
  logic [SHW-1:0]    shamt_next;
  logic [XLEN-1:0]   a_next;
  logic [XLEN-1:0]   b_next;

  // instruction fields
  assign f3      = instruction[14:12];
  assign f7      = instruction[31:25];
  assign f6      = instruction[31:26];
  assign imm     = {{(XLEN-12){instruction[31]}}, instruction[31:20]};
  assign lo_zext = {{(XLEN-WW){1'b0}}, operand_a[WW-1:0]};
  assign lo_sext = {{(XLEN-WW){operand_a[WW-1]}}, operand_a[WW-1:0]};
  assign sh_full = instruction[20 +: SHW];
  assign sh_word = {{(SHW-5){1'b0}}, instruction[24:20]};

  // decode per class
  always_comb begin
    ctl_next.op    = rv64alu_pkg::OP_ADD;
    ctl_next.word  = 1'b0;
    ctl_next.legal = 1'b0;
    a_next         = operand_a;
    b_next         = operand_b;
    shamt_next     = operand_b[SHW-1:0];
    unique case (func)
      rv64alu_pkg::CLS_OP_IMM: begin
        b_next     = imm;
        shamt_next = sh_full;
        ctl_next.legal = 1'b1;
        unique case (f3)
          rv64alu_pkg::F3_ADD:  ctl_next.op = rv64alu_pkg::OP_ADD;
          rv64alu_pkg::F3_SLT:  ctl_next.op = rv64alu_pkg::OP_SLT;
          rv64alu_pkg::F3_SLTU: ctl_next.op = rv64alu_pkg::OP_SLTU;
          rv64alu_pkg::F3_XOR:  ctl_next.op = rv64alu_pkg::OP_XOR;
          rv64alu_pkg::F3_OR:   ctl_next.op = rv64alu_pkg::OP_OR;
          rv64alu_pkg::F3_AND:  ctl_next.op = rv64alu_pkg::OP_AND;
          rv64alu_pkg::F3_SLL: begin
            ctl_next.op    = rv64alu_pkg::OP_SLL;
            ctl_next.legal = (f6 == rv64alu_pkg::F6_BASE);
          end
          default: begin
            ctl_next.op    = (f6 == rv64alu_pkg::F6_SRA) ? rv64alu_pkg::OP_SRA
                                                         : rv64alu_pkg::OP_SRL;
            ctl_next.legal = (f6 == rv64alu_pkg::F6_BASE) ||
                             (f6 == rv64alu_pkg::F6_SRA);
          end
        endcase
      end
      rv64alu_pkg::CLS_OP: begin
        if (f7 == rv64alu_pkg::F7_BASE) begin
          ctl_next.legal = 1'b1;
          unique case (f3)
            rv64alu_pkg::F3_ADD:  ctl_next.op = rv64alu_pkg::OP_ADD;
            rv64alu_pkg::F3_SLL:  ctl_next.op = rv64alu_pkg::OP_SLL;
            rv64alu_pkg::F3_SLT:  ctl_next.op = rv64alu_pkg::OP_SLT;
            rv64alu_pkg::F3_SLTU: ctl_next.op = rv64alu_pkg::OP_SLTU;
            rv64alu_pkg::F3_XOR:  ctl_next.op = rv64alu_pkg::OP_XOR;
            rv64alu_pkg::F3_SRL:  ctl_next.op = rv64alu_pkg::OP_SRL;
            rv64alu_pkg::F3_OR:   ctl_next.op = rv64alu_pkg::OP_OR;
            default:              ctl_next.op = rv64alu_pkg::OP_AND;
          endcase
        end else if (f7 == rv64alu_pkg::F7_ALT) begin
          if (f3 == rv64alu_pkg::F3_ADD) begin
            ctl_next.op    = rv64alu_pkg::OP_SUB;
            ctl_next.legal = 1'b1;
          end else if (f3 == rv64alu_pkg::F3_SRL) begin
            ctl_next.op    = rv64alu_pkg::OP_SRA;
            ctl_next.legal = 1'b1;
          end
        end
      end
      rv64alu_pkg::CLS_OP_IMM_32: begin
        b_next        = imm;
        shamt_next    = sh_word;
        ctl_next.word = 1'b1;
        if (f3 == rv64alu_pkg::F3_ADD) begin
          ctl_next.legal = 1'b1;
        end else if (f3 == rv64alu_pkg::F3_SLL) begin
          ctl_next.op = rv64alu_pkg::OP_SLL;
          if (zba_en && (f6 == rv64alu_pkg::F6_SLLI_UW)) begin
            // slli.uw: zero-extended low word, full shift, no word result
            a_next         = lo_zext;
            shamt_next     = sh_full;
            ctl_next.word  = 1'b0;
            ctl_next.legal = 1'b1;
          end else begin
            ctl_next.legal = (f7 == rv64alu_pkg::F7_BASE);
          end
        end else if (f3 == rv64alu_pkg::F3_SRL) begin
          if (f7 == rv64alu_pkg::F7_BASE) begin
            ctl_next.op    = rv64alu_pkg::OP_SRL;
            a_next         = lo_zext;
            ctl_next.legal = 1'b1;
          end else if (f7 == rv64alu_pkg::F7_ALT) begin
            ctl_next.op    = rv64alu_pkg::OP_SRA;
            a_next         = lo_sext;
            ctl_next.legal = 1'b1;
          end
        end
      end
      default: begin
        shamt_next    = {{(SHW-5){1'b0}}, operand_b[4:0]};
        ctl_next.word = 1'b1;
        if (f7 == rv64alu_pkg::F7_BASE) begin
          if (f3 == rv64alu_pkg::F3_ADD) begin
            ctl_next.legal = 1'b1;
          end else if (f3 == rv64alu_pkg::F3_SLL) begin
            ctl_next.op    = rv64alu_pkg::OP_SLL;
            ctl_next.legal = 1'b1;
          end else if (f3 == rv64alu_pkg::F3_SRL) begin
            ctl_next.op    = rv64alu_pkg::OP_SRL;
            a_next         = lo_zext;
            ctl_next.legal = 1'b1;
          end
        end else if (f7 == rv64alu_pkg::F7_ALT) begin
          if (f3 == rv64alu_pkg::F3_ADD) begin
            ctl_next.op    = rv64alu_pkg::OP_SUB;
            ctl_next.legal = 1'b1;
          end else if (f3 == rv64alu_pkg::F3_SRL) begin
            ctl_next.op    = rv64alu_pkg::OP_SRA;
            a_next         = lo_sext;
            ctl_next.legal = 1'b1;
          end
        end
      end
    endcase
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    out_ctl   <= ctl_next;
    out_shamt <= shamt_next;
    out_a     <= a_next;
    out_b     <= b_next;
    out_index <= dest_index;
  end

endmodule

// File: design/rv64alu_execute.sv
// stage 2: adder, compare, logic and barrel shifter
module rv64alu_execute #(
  parameter int XLEN = rv64alu_pkg::XLEN
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  rv64alu_pkg::ctl_t         in_ctl,
  input  logic [$clog2(XLEN)-1:0]   in_shamt,
  input  logic [XLEN-1:0]           in_a,
  input  logic [XLEN-1:0]           in_b,
  input  logic [4:0]                in_index,
  output logic                      out_valid,
  output rv64alu_pkg::ctl_t         out_ctl,
  output logic [XLEN-1:0]           out_result,
  output logic [4:0]                out_index
);

  logic            is_sub;
  logic [XLEN-1:0] b_add;
  logic [XLEN-1:0] sum;
  logic            lt_s;
  logic            lt_u;
  logic [XLEN-1:0] result_next;

  // shared add / subtract
  assign is_sub = (in_ctl.op == rv64alu_pkg::OP_SUB);
  assign b_add  = is_sub ? ~in_b : in_b;
  assign sum    = in_a + b_add + {{(XLEN-1){1'b0}}, is_sub};

  // compares
  assign lt_s = $signed(in_a) < $signed(in_b);
  assign lt_u = in_a < in_b;

  // result select
  always_comb begin
    unique case (in_ctl.op)
      rv64alu_pkg::OP_ADD,
      rv64alu_pkg::OP_SUB:  result_next = sum;
      rv64alu_pkg::OP_SLT:  result_next = {{(XLEN-1){1'b0}}, lt_s};
      rv64alu_pkg::OP_SLTU: result_next = {{(XLEN-1){1'b0}}, lt_u};
      rv64alu_pkg::OP_XOR:  result_next = in_a ^ in_b;
      rv64alu_pkg::OP_OR:   result_next = in_a | in_b;
      rv64alu_pkg::OP_AND:  result_next = in_a & in_b;
      rv64alu_pkg::OP_SLL:  result_next = in_a << in_shamt;
      rv64alu_pkg::OP_SRL:  result_next = in_a >> in_shamt;
      rv64alu_pkg::OP_SRA:  result_next = $unsigned($signed(in_a) >>> in_shamt);
      default:              result_next = sum;
    endcase
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    out_ctl    <= in_ctl;
    out_result <= result_next;
    out_index  <= in_index;
  end

endmodule

// File: design/rv64i_integer_alu.sv
// top level of the rv64i integer alu: decode, execute and writeback stages
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  command  | start, busy          | func, instruction, dest_index,
//           |                      | operand_a, operand_b
//  result   | done (one cycle)     | write_index, write_value, legal
//  config   | cfg_write            | cfg_data (zba_shift_enable)
//
// one instruction per cycle; a result shows on done once its transfer has passed
// through the decode, execute and writeback registers.
// busy is always low: the pipe never stalls and results are never held off.
// rst clears the stage valid bits and the config bit; payload regs are not reset.
module rv64i_integer_alu #(
  parameter int XLEN = rv64alu_pkg::XLEN
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  logic [1:0]      func,
  input  logic [31:0]     instruction,
  input  logic [4:0]      dest_index,
  input  logic [XLEN-1:0] operand_a,
  input  logic [XLEN-1:0] operand_b,
  output logic            done,
  output logic [4:0]      write_index,
  output logic [XLEN-1:0] write_value,
  output logic            legal,
  input  logic            cfg_write,
  input  logic            cfg_data
);

  localparam int SHW = $clog2(XLEN);
  localparam int WW  = rv64alu_pkg::WORD_W;

  logic              zba_shift_enable;
  logic              dec_valid;
  rv64alu_pkg::ctl_t dec_ctl;
  logic [SHW-1:0]    dec_shamt;
  logic [XLEN-1:0]   dec_a;
  logic [XLEN-1:0]   dec_b;
  logic [4:0]        dec_index;
  logic              exe_valid;
  rv64alu_pkg::ctl_t exe_ctl;
  logic [XLEN-1:0]   exe_result;
  logic [4:0]        exe_index;
  logic [XLEN-1:0]   value_next;

  assign busy = 1'b0;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      zba_shift_enable <= 1'b0;
    end else if (cfg_write) begin
      zba_shift_enable <= cfg_data;
    end
  end

  rv64alu_decode #(.XLEN(XLEN)) u_decode (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (start),
    .func        (func),
    .instruction (instruction),
    .dest_index  (dest_index),
    .operand_a   (operand_a),
    .operand_b   (operand_b),
    .zba_en      (zba_shift_enable),
    .out_valid   (dec_valid),
    .out_ctl     (dec_ctl),
    .out_shamt   (dec_shamt),
    .out_a       (dec_a),
    .out_b       (dec_b),
    .out_index   (dec_index)
  );

  rv64alu_execute #(.XLEN(XLEN)) u_execute (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (dec_valid),
    .in_ctl     (dec_ctl),
    .in_shamt   (dec_shamt),
    .in_a       (dec_a),
    .in_b       (dec_b),
    .in_index   (dec_index),
    .out_valid  (exe_valid),
    .out_ctl    (exe_ctl),
    .out_result (exe_result),
    .out_index  (exe_index)
  );

  // word sign extension and reserved-encoding zeroing
  always_comb begin
    if (!exe_ctl.legal) begin
      value_next = '0;
    end else if (exe_ctl.word) begin
      value_next = {{(XLEN-WW){exe_result[WW-1]}}, exe_result[WW-1:0]};
    end else begin
      value_next = exe_result;
    end
  end

  // writeback valid
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= exe_valid;
    end
  end

  // writeback payload
  always_ff @(posedge clk) begin
    write_index <= exe_index;
    write_value <= value_next;
    legal       <= exe_ctl.legal;
  end

endmodule

// File: design/rv64alu_checker.sv
// port-level checker for the rv64i integer alu and its bind
module rv64alu_checker #(
  parameter int XLEN = rv64alu_pkg::XLEN
) (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic [4:0]      dest_index,
  input logic            done,
  input logic [4:0]      write_index,
  input logic [XLEN-1:0] write_value,
  input logic            legal
);

  // pipe never pushes back
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // every transfer yields a result on done
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("result missing after transfer");

  // no result without a transfer
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##3 !done)
    else $error("result without transfer");

  // destination index carried with its item
  a_index_match: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 (write_index == $past(dest_index, 3)))
    else $error("write_index mismatch");

  // reserved encodings write zero
  a_reserved_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !legal) |-> (write_value == '0))
    else $error("reserved encoding with nonzero value");

endmodule

bind rv64i_integer_alu rv64alu_checker #(.XLEN(XLEN)) u_rv64alu_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .dest_index  (dest_index),
  .done        (done),
  .write_index (write_index),
  .write_value (write_value),
  .legal       (legal)
);
